[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the word-break RTL; clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wbs_pkg.sv]
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared widths, mode codes, queue entry type and helpers of the word-break
// segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package wbs_pkg;

  localparam int MAX_WORD_LEN_DEF = 8;
  localparam int DICT_ENTRIES_DEF = 16;

  localparam int BYTE_W = 8;
  localparam int WORD_W = 64;
  localparam int LEN_W  = 4;
  localparam int MODE_W = 2;

  // Input tdata: word_bytes, word_length, text_byte, padded to whole bytes.
  localparam int IN_WORD_LSB = 0;
  localparam int IN_LEN_LSB  = IN_WORD_LSB + WORD_W;
  localparam int IN_BYTE_LSB = IN_LEN_LSB + LEN_W;
  localparam int IN_USED_W   = IN_BYTE_LSB + BYTE_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata: prefix_ok, dict_overflow, padded to one byte.
  localparam int OUT_OK_BIT  = 0;
  localparam int OUT_OVF_BIT = 1;
  localparam int OUT_TDATA_W = 8;

  // Decoupling queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_CHAR  = 2'd1;
  localparam mode_t MODE_CLEAR = 2'd2;
  localparam mode_t MODE_NONE  = 2'd3;

  typedef struct packed {
    mode_t              kind;
    logic [WORD_W-1:0]  word;
    logic [LEN_W-1:0]   len;
    logic [BYTE_W-1:0]  text;
    logic               last;
  } op_t;

  typedef struct packed {
    logic load;
    logic clear;
  } dict_cmd_t;

  // Byte mask keeping the lowest len bytes of a word.
  function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W / BYTE_W; b++) begin
      if (LEN_W'(b) < len) begin
        m[b*BYTE_W +: BYTE_W] = {BYTE_W{1'b1}};
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/wbs_front.sv]
// ----------------------------------------------------------------------------
// wbs_front
// Accepts input items, drops the unused mode and queues the rest for the
// back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [wbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [wbs_pkg::MODE_W-1:0]      in_tuser,
  input  wire logic                            in_tlast,
  output logic                                 head_valid,
  output wbs_pkg::op_t                         head_op,
  input  wire logic                            head_pop
);

  wbs_pkg::op_t                  q_r [wbs_pkg::QUEUE_DEPTH];
  logic [wbs_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [wbs_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [wbs_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  wbs_pkg::op_t                  in_op;
  logic                          push;
  logic                          pop;

  always_comb begin
    in_op.kind = in_tuser;
    in_op.word = in_tdata[wbs_pkg::IN_WORD_LSB +: wbs_pkg::WORD_W];
    in_op.len  = in_tdata[wbs_pkg::IN_LEN_LSB +: wbs_pkg::LEN_W];
    in_op.text = in_tdata[wbs_pkg::IN_BYTE_LSB +: wbs_pkg::BYTE_W];
    in_op.last = in_tlast;
  end

  assign in_tready  = (cnt_r != wbs_pkg::QCNT_W'(wbs_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = q_r[rd_ptr_r];

  // Drop the unused mode at the door: it changes nothing downstream.
  assign push = in_tvalid && in_tready && (in_tuser != wbs_pkg::MODE_NONE);
  assign pop  = head_pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_op;
    end
  end

endmodule

`default_nettype wire

[rtl/wbs_dict.sv]
// ----------------------------------------------------------------------------
// wbs_dict
// Dictionary store with one compare lane per entry; reports whether any
// stored word ends at the current character on a segmentable prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_dict #(
  parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF,
  parameter int DICT_ENTRIES = wbs_pkg::DICT_ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wbs_pkg::dict_cmd_t                  cmd,
  input  wire logic [MAX_WORD_LEN*wbs_pkg::BYTE_W-1:0] wr_word,
  input  wire logic [wbs_pkg::LEN_W-1:0]           wr_len,
  input  wire logic [MAX_WORD_LEN*wbs_pkg::BYTE_W-1:0] text_vec,
  input  wire logic [MAX_WORD_LEN-1:0]             dp_vec,
  output logic                                     hit,
  output logic                                     overflow
);

  localparam int BW    = wbs_pkg::BYTE_W;
  localparam int WW    = MAX_WORD_LEN * BW;
  localparam int LenW  = wbs_pkg::LEN_W;
  localparam int CntW  = $clog2(DICT_ENTRIES + 1);
  localparam int IdxW  = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
  localparam int LiW   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int CandN = 1 << LiW;

  logic [WW-1:0]    word_r [DICT_ENTRIES];
  logic [LenW-1:0]  len_r  [DICT_ENTRIES];
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             full;
  logic [IdxW-1:0]  wr_idx;
  logic [WW-1:0]    cand [CandN];
  logic [CandN-1:0] dp_ext;
  logic [DICT_ENTRIES-1:0] hit_vec;

  assign full   = (cnt_r == CntW'(DICT_ENTRIES));
  assign wr_idx = cnt_r[IdxW-1:0];
  assign dp_ext = CandN'(dp_vec);

  // Candidate word for each length: oldest byte first, current char last.
  always_comb begin
    for (int l = 0; l < CandN; l++) begin
      cand[l] = '0;
    end
    for (int l = 0; l < MAX_WORD_LEN; l++) begin
      for (int m = 0; m <= l; m++) begin
        cand[l][m*BW +: BW] = text_vec[(l-m)*BW +: BW];
      end
    end
  end

  for (genvar e = 0; e < DICT_ENTRIES; e++) begin : g_lane
    logic [wbs_pkg::WORD_W-1:0] full_mask;
    logic                       len_ok;
    logic [LiW-1:0]             li;
    assign full_mask = wbs_pkg::len_mask(len_r[e]);
    assign len_ok    = (len_r[e] != '0) && (len_r[e] <= LenW'(MAX_WORD_LEN));
    assign li        = LiW'(len_r[e] - LenW'(1));
    assign hit_vec[e] = (cnt_r > CntW'(e)) && len_ok && dp_ext[li] &&
                        ((word_r[e] & full_mask[WW-1:0]) == cand[li]);
  end

  assign hit      = |hit_vec;
  assign overflow = ovf_r;

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      word_r[wr_idx] <= wr_word;
      len_r[wr_idx]  <= wr_len;
    end
  end

endmodule

`default_nettype wire

[rtl/wbs_back.sv]
// ----------------------------------------------------------------------------
// wbs_back
// Executes queued operations in order: drives dictionary updates, keeps the
// text history and segmentable window, and registers one result per char.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_back #(
  parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                head_valid,
  input  wire wbs_pkg::op_t                        head_op,
  output logic                                     head_pop,
  output wbs_pkg::dict_cmd_t                       dict_cmd,
  output logic [MAX_WORD_LEN*wbs_pkg::BYTE_W-1:0]  dict_wr_word,
  output logic [MAX_WORD_LEN*wbs_pkg::BYTE_W-1:0]  text_vec,
  output logic [MAX_WORD_LEN-1:0]                  dp_vec,
  input  wire logic                                dict_hit,
  input  wire logic                                dict_overflow,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [wbs_pkg::OUT_TDATA_W-1:0]          out_tdata,
  output logic                                     out_tlast
);

  localparam int BW = wbs_pkg::BYTE_W;
  localparam int WW = MAX_WORD_LEN * BW;

  logic [WW-1:0]           hist_r, hist_nxt;
  logic [MAX_WORD_LEN-1:0] dp_r, dp_nxt;
  logic [WW+BW-1:0]        hist_cat;
  logic [MAX_WORD_LEN:0]   dp_cat;
  logic                    out_valid_r;
  logic                    ok_r;
  logic                    last_r;
  logic                    ovf_r;
  logic                    slot_free;
  logic                    is_char;

  assign slot_free = !out_valid_r || out_tready;

  // Decode the head operation.
  always_comb begin
    is_char  = 1'b0;
    dict_cmd = '0;
    unique case (head_op.kind)
      wbs_pkg::MODE_LOAD:  dict_cmd.load  = head_valid;
      wbs_pkg::MODE_CHAR:  is_char        = head_valid;
      wbs_pkg::MODE_CLEAR: dict_cmd.clear = head_valid;
      default: ;
    endcase
  end

  // Chars wait for the output slot; loads and clears never do.
  assign head_pop     = head_valid && (!is_char || slot_free);
  assign dict_wr_word = head_op.word[WW-1:0];

  // Byte 0 is the current char, byte k the char k positions back.
  assign hist_cat = {hist_r, head_op.text};
  assign text_vec = hist_cat[WW-1:0];
  assign dp_vec   = dp_r;

  assign dp_cat = {dp_r, dict_hit};

  always_comb begin
    hist_nxt = hist_r;
    dp_nxt   = dp_r;
    if (is_char && slot_free) begin
      if (head_op.last) begin
        hist_nxt = '0;
        dp_nxt   = MAX_WORD_LEN'(1);
      end else begin
        hist_nxt = hist_cat[WW-1:0];
        dp_nxt   = dp_cat[MAX_WORD_LEN-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r      <= '0;
      dp_r        <= MAX_WORD_LEN'(1);
      out_valid_r <= 1'b0;
    end else begin
      hist_r <= hist_nxt;
      dp_r   <= dp_nxt;
      if (is_char && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_char && slot_free) begin
      ok_r   <= dict_hit;
      last_r <= head_op.last;
      ovf_r  <= dict_overflow;
    end
  end

  always_comb begin
    out_tdata                       = '0;
    out_tdata[wbs_pkg::OUT_OK_BIT]  = ok_r;
    out_tdata[wbs_pkg::OUT_OVF_BIT] = ovf_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

[rtl/word_break_segmenter_unit.sv]
// ----------------------------------------------------------------------------
// word_break_segmenter_unit
// Streaming word-break decision: dictionary loads, clears and text chars in,
// one segmentable flag out per text char.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per handshake. in_tuser selects load (0), char (1) or
//           clear (2); code 3 is accepted and dropped. in_tlast ends a text.
//   out_* : one item per text char; out_tlast echoes the end of text, and
//           out_tdata carries prefix_ok and the sticky dictionary overflow.
//   An accepted char is queued, and its result registered as it leaves the head.
//   Throughput: one item per cycle while the receiver keeps up. Every dictionary
//   entry compares against the matching tail of the text in its own lane in the
//   same cycle, so the segmentable window only ever waits on one compare and OR.
//   A two-entry queue separates the accepting front from the executing back;
//   a stalled receiver holds the result register, chars back up in the
//   queue, and in_tready drops once the queue is full. Loads and clears keep
//   draining while a result waits.
//   Reset empties the dictionary and queue, clears the overflow flag and
//   text history, and marks the empty prefix segmentable. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module word_break_segmenter_unit #(
  parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF,
  parameter int DICT_ENTRIES = wbs_pkg::DICT_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // in_tdata, low bit up: word_bytes[63:0], word_length[67:64],
  // text_byte[75:68], zero pad[79:76]
  input  wire logic [wbs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: mode[1:0]
  input  wire logic [wbs_pkg::MODE_W-1:0]       in_tuser,
  input  wire logic                             in_tlast,
  // Result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_tdata, low bit up: prefix_ok[0], dict_overflow[1], zero pad[7:2]
  output logic [wbs_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);

  localparam int WW = MAX_WORD_LEN * wbs_pkg::BYTE_W;

  logic                    head_valid;
  wbs_pkg::op_t            head_op;
  logic                    head_pop;
  wbs_pkg::dict_cmd_t      dict_cmd;
  logic [WW-1:0]           dict_wr_word;
  logic [WW-1:0]           text_vec;
  logic [MAX_WORD_LEN-1:0] dp_vec;
  logic                    dict_hit;
  logic                    dict_overflow;
  logic                    char_to_slot;

  // Front: accept and classify, queue for the back.
  wbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .head_valid (head_valid),
    .head_op    (head_op),
    .head_pop   (head_pop)
  );

  // Dictionary lanes and overflow flag.
  wbs_dict #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_dict (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (dict_cmd),
    .wr_word  (dict_wr_word),
    .wr_len   (head_op.len),
    .text_vec (text_vec),
    .dp_vec   (dp_vec),
    .hit      (dict_hit),
    .overflow (dict_overflow)
  );

  // Back: execute in order, hold the window, register results.
  wbs_back #(
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_op       (head_op),
    .head_pop      (head_pop),
    .dict_cmd      (dict_cmd),
    .dict_wr_word  (dict_wr_word),
    .text_vec      (text_vec),
    .dp_vec        (dp_vec),
    .dict_hit      (dict_hit),
    .dict_overflow (dict_overflow),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

  // A char sits at the head and the output slot can take its result.
  assign char_to_slot = head_valid && (head_op.kind == wbs_pkg::MODE_CHAR) &&
                        (!out_tvalid || out_tready);

  // Never pop an empty queue.
  `WBS_ASSERT_NOW(a_pop_needs_head, head_pop, head_valid, "pop from empty queue")

  // A char reaching a free output slot yields a result next cycle.
  `WBS_ASSERT_NEXT(a_char_gives_result, char_to_slot, out_tvalid, "char popped without result")

  // The overflow flag is sticky until reset.
  `WBS_ASSERT_NEXT(a_overflow_sticky, dict_overflow, dict_overflow, "overflow flag dropped")

endmodule

`default_nettype wire

[tb/wbs_segment_checker.sv]
// ----------------------------------------------------------------------------
// wbs_segment_checker
// Watches both streams of the word-break segmenter, keeps its own copy of
// the dictionary and segmentable window, and compares every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module wbs_segment_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  // word_bytes, word_length, text_byte, zero pad
  input  wire logic [wbs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode
  input  wire logic [wbs_pkg::MODE_W-1:0]       in_tuser,
  input  wire logic                             in_tlast,
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  // prefix_ok, dict_overflow, zero pad
  input  wire logic [wbs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                             out_tlast,
  output int                                    failures,
  output int                                    pending,
  output int                                    chars_checked,
  output int                                    texts_split,
  output int                                    loads_dropped
);
  import wbs_pkg::*;

  localparam int HIST_DEPTH  = MAX_WORD_LEN_DEF - 1;

  typedef struct packed {
    logic prefix_ok;
    logic text_done;
    logic dict_overflow;
  } seg_result_t;

  seg_result_t        seg_expect_q [$];

  logic [WORD_W-1:0]  dict_word [DICT_ENTRIES_DEF];
  logic [LEN_W-1:0]   dict_len  [DICT_ENTRIES_DEF];
  int                 dict_fill;
  logic [BYTE_W-1:0]  hist [HIST_DEPTH];
  logic [7:0]         dp_bits;
  logic               ovf_seen;

  function automatic logic [WORD_W-1:0] byte_span(input int n);
    if (n >= WORD_W / BYTE_W) begin
      return '1;
    end
    return (WORD_W'(1) << (BYTE_W * n)) - WORD_W'(1);
  endfunction

  // True when the last n chars, ending in ch, equal a live dictionary word.
  function automatic logic suffix_in_dict(input int n, input logic [BYTE_W-1:0] ch);
    logic [WORD_W-1:0] tail;
    tail = '0;
    for (int m = 0; m < n; m++) begin
      tail[BYTE_W*m +: BYTE_W] = (m == n - 1) ? ch : hist[n-2-m];
    end
    for (int e = 0; e < dict_fill; e++) begin
      if (dict_len[e] == LEN_W'(n) && (dict_word[e] & byte_span(n)) == tail) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic report(input string field, input logic want, input logic got);
    failures++;
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
  endtask

  always @(posedge clk) begin : monitor
    seg_result_t       want;
    seg_result_t       got;
    logic              ok;
    logic [BYTE_W-1:0] ch;
    if (!rst_n) begin
      dict_fill     = 0;
      dp_bits       = 8'd1;
      ovf_seen      = 1'b0;
      failures      = 0;
      chars_checked = 0;
      texts_split   = 0;
      loads_dropped = 0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        hist[k] = '0;
      end
      seg_expect_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_LOAD: begin
            if (dict_fill < DICT_ENTRIES_DEF) begin
              dict_word[dict_fill] = in_tdata[IN_WORD_LSB +: WORD_W];
              dict_len[dict_fill]  = in_tdata[IN_LEN_LSB +: LEN_W];
              dict_fill++;
            end else begin
              ovf_seen = 1'b1;
              loads_dropped++;
            end
          end
          MODE_CLEAR: begin
            dict_fill = 0;
          end
          MODE_CHAR: begin
            ch = in_tdata[IN_BYTE_LSB +: BYTE_W];
            ok = 1'b0;
            for (int n = 1; n <= MAX_WORD_LEN_DEF; n++) begin
              if (!ok && dp_bits[n-1] && suffix_in_dict(n, ch)) begin
                ok = 1'b1;
              end
            end
            want.prefix_ok     = ok;
            want.text_done     = in_tlast;
            want.dict_overflow = ovf_seen;
            seg_expect_q.push_back(want);
            // end of text: restart with only the empty prefix valid
            if (in_tlast) begin
              dp_bits = 8'd1;
              for (int k = 0; k < HIST_DEPTH; k++) begin
                hist[k] = '0;
              end
            end else begin
              dp_bits = {dp_bits[6:0], ok};
              for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                hist[k] = hist[k-1];
              end
              hist[0] = ch;
            end
          end
          default: begin
          end
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.prefix_ok     = out_tdata[OUT_OK_BIT];
        got.text_done     = out_tlast;
        got.dict_overflow = out_tdata[OUT_OVF_BIT];
        if (seg_expect_q.size() == 0) begin
          failures++;
          $error("result item arrived with no char waiting for one");
        end else begin
          want = seg_expect_q.pop_front();
          chars_checked++;
          if (want.text_done && want.prefix_ok) begin
            texts_split++;
          end
          if (got.prefix_ok !== want.prefix_ok) begin
            report("prefix_ok", want.prefix_ok, got.prefix_ok);
          end
          if (got.text_done !== want.text_done) begin
            report("text_done", want.text_done, got.text_done);
          end
          if (got.dict_overflow !== want.dict_overflow) begin
            report("dict_overflow", want.dict_overflow, got.dict_overflow);
          end
        end
      end
    end
    pending <= seg_expect_q.size();
  end

endmodule

`default_nettype wire

[tb/word_break_segmenter_unit_tb.sv]
// ----------------------------------------------------------------------------
// word_break_segmenter_unit_tb
// Drives dictionary loads, clears and texts into the word-break segmenter,
// mostly texts built from the loaded words, under shifting stall patterns;
// a side checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`default_nettype none

module word_break_segmenter_unit_tb;
  import wbs_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic [MODE_W-1:0]       in_tuser   = MODE_NONE;
  logic                    in_tlast   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;

  int failures;
  int pending;
  int chars_checked;
  int texts_split;
  int loads_dropped;

  int tx_idle_pct  = 33;
  int rx_idle_pct  = 75;
  int items_sent   = 0;
  int quiet_cycles = 0;

  // What the block holds, kept only to build texts that can be split.
  logic [WORD_W-1:0] lex_word [$];
  logic [LEN_W-1:0]  lex_len  [$];
  int                lex_fill = 0;

  word_break_segmenter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  wbs_segment_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .failures      (failures),
    .pending       (pending),
    .chars_checked (chars_checked),
    .texts_split   (texts_split),
    .loads_dropped (loads_dropped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Mostly a three-letter alphabet so that words and texts collide often.
  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(99) < 80) begin
      return 8'h61 + BYTE_W'($urandom_range(2));
    end
    return BYTE_W'($urandom_range(255));
  endfunction

  // Present one item, idling first at the sender's rate, and hold it until
  // taken. Sample in_tready at the falling edge, where it is settled.
  task automatic send_item(input mode_t mode, input logic [WORD_W-1:0] word,
                           input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] text,
                           input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_TDATA_W'({text, len, word});
    in_tlast  <= last;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    if (mode != MODE_NONE) begin
      items_sent++;
    end
  endtask

  // Load a word; unused text fields carry noise.
  task automatic load_word(input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len);
    if (lex_fill < DICT_ENTRIES_DEF) begin
      lex_fill++;
      if (len >= 1 && len <= MAX_WORD_LEN_DEF) begin
        lex_word.push_back(word);
        lex_len.push_back(len);
      end
    end
    send_item(MODE_LOAD, word, len, BYTE_W'($urandom), 1'($urandom));
  endtask

  task automatic clear_dict();
    lex_fill = 0;
    lex_word.delete();
    lex_len.delete();
    send_item(MODE_CLEAR, {$urandom, $urandom}, LEN_W'($urandom), BYTE_W'($urandom),
              1'($urandom));
  endtask

  task automatic send_char(input logic [BYTE_W-1:0] ch, input logic last);
    send_item(MODE_CHAR, {$urandom, $urandom}, LEN_W'($urandom), ch, last);
  endtask

  // Mostly short words; bytes past the length keep random garbage. A few
  // lengths are out of range: stored but never matched.
  task automatic load_random_word();
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
    int                r;
    int                v;
    word = {$urandom, $urandom};
    r    = $urandom_range(99);
    if (r < 60) begin
      len = LEN_W'($urandom_range(1, 3));
    end else if (r < 92) begin
      len = LEN_W'($urandom_range(4, MAX_WORD_LEN_DEF));
    end else begin
      v   = $urandom_range(7);
      len = (v == 0) ? '0 : LEN_W'(v + 8);
    end
    for (int b = 0; b < len && b < MAX_WORD_LEN_DEF; b++) begin
      word[BYTE_W*b +: BYTE_W] = pick_byte();
    end
    load_word(word, len);
  endtask

  // One text: a chain of loaded words, now and then a stray or altered char,
  // with rare loads and dropped mode codes slipped in between chars.
  task automatic send_random_text();
    logic [BYTE_W-1:0] chars [$];
    int                idx;
    repeat ($urandom_range(1, 5)) begin
      if (lex_len.size() > 0 && $urandom_range(99) < 85) begin
        idx = $urandom_range(lex_len.size() - 1);
        for (int b = 0; b < lex_len[idx]; b++) begin
          chars.push_back(lex_word[idx][BYTE_W*b +: BYTE_W]);
        end
      end else begin
        chars.push_back(pick_byte());
      end
    end
    if ($urandom_range(99) < 20) begin
      chars[$urandom_range(chars.size() - 1)] = pick_byte();
    end
    for (int i = 0; i < chars.size(); i++) begin
      if ($urandom_range(99) < 2) begin
        send_item(MODE_NONE, {$urandom, $urandom}, LEN_W'($urandom), BYTE_W'($urandom),
                  1'($urandom));
      end else if ($urandom_range(99) < 2) begin
        load_random_word();
      end
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // Hold the input until every char already taken has its result back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int random_goal;
    int phase;
    int n_loads;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty dictionary, garbage above the length, the longest
    // word of all-ones bytes, out-of-range lengths, the unused mode, and a
    // clear followed by a char that no longer matches.
    send_char(8'h61, 1'b1);
    load_word(64'hFFEE_DDCC_BBAA_9961, 4'd1);
    load_word(64'h0000_0000_0000_6261, 4'd2);
    load_word('1, 4'd8);
    load_word('0, 4'd0);
    load_word(64'h0000_0000_0000_0061, 4'd15);
    send_item(MODE_NONE, {$urandom, $urandom}, LEN_W'($urandom), BYTE_W'($urandom), 1'b1);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h61, 1'b1);
    repeat (7) send_char(8'hFF, 1'b0);
    send_char(8'hFF, 1'b1);
    clear_dict();
    send_char(8'h61, 1'b1);

    // Random: dictionary sets, sometimes overfilled, each followed by texts.
    random_goal = items_sent + ITEM_TARGET;
    phase       = 0;
    while (items_sent < random_goal) begin
      if (phase < 2 && items_sent >= random_goal - ITEM_TARGET * (2 - phase) / 3) begin
        drain_results();
        phase++;
        tx_idle_pct = (phase == 1) ? 75 : 0;
        rx_idle_pct = (phase == 1) ? 33 : 0;
      end
      if (lex_fill == 0 || $urandom_range(99) < 60) begin
        clear_dict();
        n_loads = ($urandom_range(99) < 12) ? $urandom_range(17, 20) : $urandom_range(1, 12);
      end else begin
        n_loads = $urandom_range(1, 4);
      end
      repeat (n_loads) load_random_word();
      repeat ($urandom_range(1, 4)) send_random_text();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d chars checked, %0d texts fully split, %0d loads dropped as full",
             chars_checked, texts_split, loads_dropped);
    $display("  across three stall patterns, with %0d items sent in all", items_sent);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
